@@ rtl/core/bb3_pkg.sv @@
package bb3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 8;

  // column index into the line stores, clamped width, row counter (runs to height + 1)
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 2);

  localparam int CH_W        = 8;
  localparam int WIN_N       = 9;
  localparam int SUM_W       = $clog2(WIN_N * ((1 << CH_W) - 1) + 1);
  localparam int CNT_W       = $clog2(WIN_N + 1);
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef pixel_t [WIN_N-1:0] nbhd_t;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_done;
  } out_beat_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } line_rd_t;

  typedef struct packed {
    logic left_out;
    logic right_out;
    logic top_out;
    logic bot_out;
    logic done;
  } edge_flags_t;

  typedef struct packed {
    pixel_t           pix;
    logic [COL_W-1:0] col;
    logic             have;
    edge_flags_t      flags;
  } scan_item_t;

  function automatic logic [WD_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    if (v == '0) return WD_W'(1);
    if (int'(v) > MAX_WIDTH) return WD_W'(MAX_WIDTH);
    return WD_W'(v);
  endfunction

  function automatic logic [HT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    if (v == '0) return HT_W'(1);
    if (int'(v) > MAX_HEIGHT) return HT_W'(MAX_HEIGHT);
    return HT_W'(v);
  endfunction

  // ceil(2^shift / n); exact floor division for every sum the window can produce
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      CNT_W'(2): r = RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2);
      CNT_W'(3): r = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
      CNT_W'(4): r = RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4);
      CNT_W'(6): r = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
      CNT_W'(9): r = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
      default:   r = RECIP_W'(1 << RECIP_SHIFT);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/box_blur_3x3_edge_aware.sv @@
// 3x3 box filter over an RGB raster stream, averaging only the neighbors that lie
// inside the frame (divisor 9 on the interior, 6 on edges, 4 in corners, fewer for
// frames one pixel wide or high); each channel mean is truncated. One beat is taken
// every clock when the result side keeps up. Position tracking and the two line-store
// reads share the first registered stage, then the window shift, the sums and the
// reciprocal multiply each take one more. A pixel's neighborhood is completed by the
// beat a row plus one pixel later, so after the last pixel of a frame send width + 1
// flush beats (req_type = 1); frame_done marks the result for the last pixel, after
// which a new frame starts. Flush beats sent while pixels are still due are dropped,
// and pixel beats past the end of the frame act as flush beats. Writing frame_width
// or frame_height (0 reads as 1, values above 2048 saturate) restarts the frame;
// write them only when the block is idle. The line stores are plain RAMs with no
// clearing after reset.
module box_blur_3x3_edge_aware (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  bb3_pkg::in_beat_t             pix,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bb3_pkg::out_beat_t            res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);

  logic                 item_valid, item_ready;
  bb3_pkg::scan_item_t  item;
  bb3_pkg::line_rd_t    rd;
  logic                 nb_valid, nb_ready;
  bb3_pkg::nbhd_t       nb_win;
  bb3_pkg::edge_flags_t nb_flags;

  bb3_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .rd         (rd)
  );

  bb3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .rd         (rd),
    .nb_valid   (nb_valid),
    .nb_win     (nb_win),
    .nb_flags   (nb_flags),
    .nb_ready   (nb_ready)
  );

  bb3_average u_average (
    .clk       (clk),
    .rst       (rst),
    .nb_valid  (nb_valid),
    .nb_win    (nb_win),
    .nb_flags  (nb_flags),
    .nb_ready  (nb_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

`ifndef SYNTHESIS
  // a stalled neighborhood must not see the window shift under it
  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    (nb_valid && !nb_ready) |-> !(item_valid && item_ready))
    else $error("window shifted while its neighborhood was stalled");

  // a stalled position stage must block new beats, or its ram read data is lost
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_ready) |-> !pix_ready)
    else $error("beat taken while the position stage was stalled");

  // a neighborhood only appears behind a beat from the position stage
  a_nb_source: assert property (@(posedge clk) disable iff (rst)
    (!nb_valid && !item_valid) |=> !nb_valid)
    else $error("neighborhood appeared without a beat behind it");
`endif

endmodule

@@ rtl/core/bb3_ram.sv @@
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bb3_scan.sv @@
module bb3_scan (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  bb3_pkg::in_beat_t                    pix,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]            cfg_data,
  output logic                                 item_valid,
  output bb3_pkg::scan_item_t                  item,
  input  logic                                 item_ready,
  output bb3_pkg::line_rd_t                    rd
);

  logic [bb3_pkg::WD_W-1:0]  width;
  logic [bb3_pkg::HT_W-1:0]  height;
  logic [bb3_pkg::COL_W-1:0] col, col_next;
  logic [bb3_pkg::HT_W-1:0]  row, row_next;
  logic [bb3_pkg::COL_W-1:0] c;
  logic                      flushing, ignore, accept, take, wrap, first_col;
  logic                      wr_width, wr_height;
  bb3_pkg::scan_item_t       item_next;

  assign cfg_ready = 1'b1;
  assign wr_width  = cfg_valid && (cfg_index == bb3_pkg::REG_FRAME_WIDTH);
  assign wr_height = cfg_valid && (cfg_index == bb3_pkg::REG_FRAME_HEIGHT);

  always_comb begin
    c         = (bb3_pkg::WD_W'(col) >= width) ? '0 : col;
    first_col = (c == '0);
    flushing  = row >= height;
    ignore    = !flushing && pix.req_type;
    pix_ready = !item_valid || item_ready;
    accept    = pix_valid && pix_ready;
    take      = accept && !ignore;
    wrap      = (bb3_pkg::WD_W'(c) + bb3_pkg::WD_W'(1)) >= width;

    item_next.pix = flushing ? '0 : bb3_pkg::pixel_t'{red:   pix.in_red,
                                                      green: pix.in_green,
                                                      blue:  pix.in_blue};
    item_next.col = c;
    // first column finishes the previous row's last pixel
    item_next.have            = first_col ? (row >= bb3_pkg::HT_W'(2))
                                          : (row >= bb3_pkg::HT_W'(1));
    item_next.flags.left_out  = (c == bb3_pkg::COL_W'(1)) || (width == bb3_pkg::WD_W'(1));
    item_next.flags.right_out = first_col;
    item_next.flags.top_out   = first_col ? (row == bb3_pkg::HT_W'(2))
                                          : (row == bb3_pkg::HT_W'(1));
    item_next.flags.bot_out   = first_col ? (row > height) : (row >= height);
    item_next.flags.done      = first_col && (row == height + bb3_pkg::HT_W'(1));

    rd.en   = take;
    rd.addr = c;

    col_next = col;
    row_next = row;
    if (wr_width || wr_height) begin
      col_next = '0;
      row_next = '0;
    end else if (take) begin
      if (item_next.flags.done) begin
        col_next = '0;
        row_next = '0;
      end else if (wrap) begin
        col_next = '0;
        row_next = row + bb3_pkg::HT_W'(1);
      end else begin
        col_next = c + bb3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= bb3_pkg::clamp_width(bb3_pkg::CFG_W'(bb3_pkg::RESET_WIDTH));
      height     <= bb3_pkg::clamp_height(bb3_pkg::CFG_W'(bb3_pkg::RESET_HEIGHT));
      col        <= '0;
      row        <= '0;
      item_valid <= 1'b0;
    end else begin
      if (wr_width) begin
        width <= bb3_pkg::clamp_width(cfg_data);
      end
      if (wr_height) begin
        height <= bb3_pkg::clamp_height(cfg_data);
      end
      col <= col_next;
      row <= row_next;
      if (take) begin
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/core/bb3_window.sv @@
module bb3_window (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  bb3_pkg::scan_item_t   item,
  output logic                  item_ready,
  input  bb3_pkg::line_rd_t     rd,
  output logic                  nb_valid,
  output bb3_pkg::nbhd_t        nb_win,
  output bb3_pkg::edge_flags_t  nb_flags,
  input  logic                  nb_ready
);

  logic            item_fire;
  logic            fwd_hit;
  bb3_pkg::pixel_t fwd_top, fwd_mid;
  bb3_pkg::pixel_t upper_q, lower_q;
  bb3_pkg::pixel_t top_px, mid_px;

  // window is shared with the next stage, so shift only when that stage is free
  assign item_ready = !nb_valid || nb_ready;
  assign item_fire  = item_valid && item_ready;
  assign top_px     = fwd_hit ? fwd_top : upper_q;
  assign mid_px     = fwd_hit ? fwd_mid : lower_q;

  bb3_ram #(
    .WIDTH ($bits(bb3_pkg::pixel_t)),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (item_fire),
    .waddr (item.col),
    .wdata (mid_px),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (upper_q)
  );

  bb3_ram #(
    .WIDTH ($bits(bb3_pkg::pixel_t)),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (item_fire),
    .waddr (item.col),
    .wdata (item.pix),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (lower_q)
  );

  // read and write of the same column on one edge (one-pixel-wide frame, or the
  // beat right after a frame ends): bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd.en) begin
      fwd_hit <= item_fire && (item.col == rd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_top <= mid_px;
      fwd_mid <= item.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_win   <= '0;
      nb_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        for (int i = 0; i < 6; i++) begin
          nb_win[i] <= nb_win[i+3];
        end
        nb_win[6] <= top_px;
        nb_win[7] <= mid_px;
        nb_win[8] <= item.pix;
        nb_valid  <= item.have;
      end else if (nb_ready) begin
        nb_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      nb_flags <= item.flags;
    end
  end

endmodule

@@ rtl/core/bb3_average.sv @@
module bb3_average (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  nb_valid,
  input  bb3_pkg::nbhd_t        nb_win,
  input  bb3_pkg::edge_flags_t  nb_flags,
  output logic                  nb_ready,
  output logic                  res_valid,
  output bb3_pkg::out_beat_t    res,
  input  logic                  res_ready
);

  typedef logic [bb3_pkg::WIN_N-1:0][bb3_pkg::CH_W-1:0] chan_vec_t;

  function automatic logic [bb3_pkg::SUM_W-1:0] sum9(input chan_vec_t v);
    logic [bb3_pkg::CH_W+1:0] c0, c1, c2;
    c0 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]};
    c1 = {2'b00, v[3]} + {2'b00, v[4]} + {2'b00, v[5]};
    c2 = {2'b00, v[6]} + {2'b00, v[7]} + {2'b00, v[8]};
    return bb3_pkg::SUM_W'(c0) + bb3_pkg::SUM_W'(c1) + bb3_pkg::SUM_W'(c2);
  endfunction

  chan_vec_t                      red_v, green_v, blue_v;
  logic [1:0]                     ncols, nrows;
  logic [bb3_pkg::CNT_W-1:0]      cnt;
  logic                           sum_valid, sum_ready;
  logic [bb3_pkg::SUM_W-1:0]      sum_red, sum_green, sum_blue;
  logic [bb3_pkg::RECIP_W-1:0]    sum_recip;
  logic                           sum_done;
  logic [bb3_pkg::SUM_W+bb3_pkg::RECIP_W-1:0] prod_red, prod_green, prod_blue;

  assign sum_ready = !res_valid || res_ready;
  assign nb_ready  = !sum_valid || sum_ready;

  always_comb begin
    for (int i = 0; i < bb3_pkg::WIN_N; i++) begin
      // index is column * 3 + row
      if (((i / 3 == 0) && nb_flags.left_out) || ((i / 3 == 2) && nb_flags.right_out) ||
          ((i % 3 == 0) && nb_flags.top_out) || ((i % 3 == 2) && nb_flags.bot_out)) begin
        red_v[i]   = '0;
        green_v[i] = '0;
        blue_v[i]  = '0;
      end else begin
        red_v[i]   = nb_win[i].red;
        green_v[i] = nb_win[i].green;
        blue_v[i]  = nb_win[i].blue;
      end
    end
    ncols = 2'd3 - {1'b0, nb_flags.left_out} - {1'b0, nb_flags.right_out};
    nrows = 2'd3 - {1'b0, nb_flags.top_out} - {1'b0, nb_flags.bot_out};
    cnt   = {2'b00, ncols} * {2'b00, nrows};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (nb_ready) begin
      sum_valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (nb_valid && nb_ready) begin
      sum_red   <= sum9(red_v);
      sum_green <= sum9(green_v);
      sum_blue  <= sum9(blue_v);
      sum_recip <= bb3_pkg::recip(cnt);
      sum_done  <= nb_flags.done;
    end
  end

  // divide by 1..9 as a multiply by the rounded-up reciprocal
  assign prod_red   = {{bb3_pkg::RECIP_W{1'b0}}, sum_red}   * {{bb3_pkg::SUM_W{1'b0}}, sum_recip};
  assign prod_green = {{bb3_pkg::RECIP_W{1'b0}}, sum_green} * {{bb3_pkg::SUM_W{1'b0}}, sum_recip};
  assign prod_blue  = {{bb3_pkg::RECIP_W{1'b0}}, sum_blue}  * {{bb3_pkg::SUM_W{1'b0}}, sum_recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sum_ready) begin
      res_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      res.out_red    <= prod_red[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
      res.out_green  <= prod_green[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
      res.out_blue   <= prod_blue[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
      res.frame_done <= sum_done;
    end
  end

endmodule
